### hw/rtl/rgbc_pkg.sv
// Shared types, constants and kernel tables for the RGB 3x3 convolution filter.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package rgbc_pkg;

  // Default frame limits handed to the top level parameters.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Fixed geometry and field widths.
  localparam int KSIZE     = 3;
  localparam int NTAPS     = KSIZE * KSIZE;
  localparam int COEF_BITS = 8;
  localparam int CH_BITS   = 8;
  localparam int NCH       = 3;
  localparam int PIX_BITS  = NCH * CH_BITS;
  localparam int DIM_BITS  = 11;
  localparam int SEL_BITS  = 3;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = KSIZE * COEF_BITS;
  localparam int COORD_BITS    = 10;
  localparam int FRAME_DIM_RST = 1024;

  // Datapath widths: pixel times coefficient, nine-term sum, magnitude, divisor.
  localparam int PROD_BITS = CH_BITS + COEF_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 4;
  localparam int MAG_BITS  = SUM_BITS - 1;
  localparam int DIV_BITS  = COEF_BITS + 4;
  localparam int QBITS     = CH_BITS;

  typedef logic [PIX_BITS-1:0]                    pix_t;
  typedef logic [NTAPS-1:0][PIX_BITS-1:0]         win_t;
  typedef logic [SEL_BITS-1:0]                    ksel_t;
  typedef logic signed [COEF_BITS-1:0]            coef_t;
  typedef logic signed [DIV_BITS-1:0]             divs_t;
  typedef logic [KSIZE-1:0][CFG_DATA_BITS-1:0]    rows_t;
  typedef logic [NCH-1:0][CH_BITS-1:0]            chans_t;

  // Result of the multiply-accumulate unit for one output pixel.
  typedef struct packed {
    logic [NCH-1:0][MAG_BITS-1:0] mag;
    divs_t                        divisor;
  } conv_res_t;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_KSEL       = 3'd0,
    REG_ROW_TOP    = 3'd1,
    REG_ROW_MID    = 3'd2,
    REG_ROW_BOTTOM = 3'd3,
    REG_WIDTH      = 3'd4,
    REG_HEIGHT     = 3'd5
  } cfg_reg_t;

  // Input item kinds.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Kernel selection codes.
  localparam ksel_t KSEL_CUSTOM = 3'd0;
  localparam ksel_t KSEL_MEAN   = 3'd1;

  // Built-in kernels, row-major, row 0 first.
  localparam coef_t KTAB [8][NTAPS] = '{
    '{ 0,  0,  0,  0,   0,  0,  0,  0,  0},
    '{ 1,  1,  1,  1,   1,  1,  1,  1,  1},
    '{ 1,  2,  1,  2, -12,  2,  1,  2,  1},
    '{ 1,  1,  1,  1,   8,  1,  1,  1,  1},
    '{ 0, -1,  0, -1,   5, -1,  0, -1,  0},
    '{ 0,  1,  0,  1,  -4,  1,  0,  1,  0},
    '{-1,  0,  1, -2,   0,  2, -1,  0,  1},
    '{-1, -2, -1,  0,   0,  0,  1,  2,  1}
  };

  // Divisors of the built-in kernels; the custom entry is never used.
  localparam divs_t KDIV [8] = '{1, 9, 1, 16, 5, 1, 4, 4};

  // State machine of the top level controller.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_VISIT = 6'b000010,
    S_RD    = 6'b000100,
    S_CONV  = 6'b001000,
    S_DIV   = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/rgbc_line_mem.sv
// Two-row line store: one synchronous memory holding the upper and lower rows side by side.
// Uses rgbc_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_line_mem #(
  parameter int DEPTH = rgbc_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [$clog2(DEPTH)-1:0]          waddr,
  input  wire logic [2*rgbc_pkg::PIX_BITS-1:0]   wdata,
  input  wire logic                              re,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr,
  output logic      [2*rgbc_pkg::PIX_BITS-1:0]   rdata
);

  logic [2*rgbc_pkg::PIX_BITS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rgbc_conv.sv
// Multiply-accumulate unit: 3x3 window times rotated kernel, absolute value, divisor select.
// Uses rgbc_pkg for types and kernel tables; two register stages.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_conv (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire rgbc_pkg::win_t       win,
  input  wire rgbc_pkg::ksel_t      ksel,
  input  wire rgbc_pkg::rows_t      custom,
  output logic                      done,
  output rgbc_pkg::conv_res_t       res
);

  rgbc_pkg::coef_t coef [rgbc_pkg::NTAPS];
  rgbc_pkg::divs_t csum;
  rgbc_pkg::divs_t div_c;
  rgbc_pkg::divs_t div1;
  logic signed [rgbc_pkg::PROD_BITS-1:0] prod [rgbc_pkg::NCH][rgbc_pkg::NTAPS];
  logic signed [rgbc_pkg::SUM_BITS-1:0]  acc [rgbc_pkg::NCH];
  logic v1;

  // Coefficient selection and divisor of the active kernel.
  always_comb begin
    int k;
    csum = '0;
    for (int r = 0; r < rgbc_pkg::KSIZE; r++) begin
      for (int c = 0; c < rgbc_pkg::KSIZE; c++) begin
        k = r * rgbc_pkg::KSIZE + c;
        if (ksel == rgbc_pkg::KSEL_CUSTOM) begin
          coef[k] = rgbc_pkg::coef_t'(custom[r][c*rgbc_pkg::COEF_BITS +: rgbc_pkg::COEF_BITS]);
        end else begin
          coef[k] = rgbc_pkg::KTAB[ksel][k];
        end
        csum = csum + rgbc_pkg::DIV_BITS'(coef[k]);
      end
    end
    if (ksel == rgbc_pkg::KSEL_CUSTOM) begin
      div_c = (csum == '0) ? rgbc_pkg::DIV_BITS'(1) : csum;
    end else begin
      div_c = rgbc_pkg::KDIV[ksel];
    end
  end

  // Stage one: products; tap t meets coefficient 8 - t, the kernel turned by 180 degrees.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < rgbc_pkg::NCH; ch++) begin
      for (int t = 0; t < rgbc_pkg::NTAPS; t++) begin
        prod[ch][t] <= $signed(rgbc_pkg::PROD_BITS'(
                         win[t][(rgbc_pkg::NCH-1-ch)*rgbc_pkg::CH_BITS +: rgbc_pkg::CH_BITS]))
                       * rgbc_pkg::PROD_BITS'(coef[rgbc_pkg::NTAPS-1-t]);
      end
    end
    div1 <= div_c;
  end

  // Sum of the nine products per channel.
  always_comb begin
    for (int ch = 0; ch < rgbc_pkg::NCH; ch++) begin
      acc[ch] = '0;
      for (int t = 0; t < rgbc_pkg::NTAPS; t++) begin
        acc[ch] = acc[ch] + rgbc_pkg::SUM_BITS'(prod[ch][t]);
      end
    end
  end

  // Stage two: magnitudes.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < rgbc_pkg::NCH; ch++) begin
      res.mag[ch] <= acc[ch][rgbc_pkg::SUM_BITS-1] ? rgbc_pkg::MAG_BITS'(-acc[ch])
                                                   : rgbc_pkg::MAG_BITS'(acc[ch]);
    end
    res.divisor <= div1;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rgbc_div.sv
// Iterative divider: three channel lanes, one quotient bit per cycle, result clamped to 255.
// Uses rgbc_pkg for widths and the conv_res_t input.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire rgbc_pkg::conv_res_t  res,
  output logic                      done,
  output rgbc_pkg::chans_t          quo
);

  localparam int CNTW = $clog2(rgbc_pkg::QBITS);

  logic [rgbc_pkg::DIV_BITS-2:0]      dpos;
  logic [rgbc_pkg::MAG_BITS-1:0]      dsh;
  logic [rgbc_pkg::MAG_BITS-1:0]      rem [rgbc_pkg::NCH];
  logic [rgbc_pkg::QBITS-1:0]         q   [rgbc_pkg::NCH];
  logic [rgbc_pkg::NCH-1:0]           sat;
  logic                               zero;
  logic                               busy;
  logic [CNTW-1:0]                    cnt;

  assign dpos = res.divisor[rgbc_pkg::DIV_BITS-2:0];

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(rgbc_pkg::QBITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division; a quotient of 256 or more is flagged up front as saturated.
  always_ff @(posedge clk) begin
    if (start) begin
      zero <= (res.divisor <= 0);
      dsh  <= rgbc_pkg::MAG_BITS'(dpos) << (rgbc_pkg::QBITS - 1);
      for (int ch = 0; ch < rgbc_pkg::NCH; ch++) begin
        rem[ch] <= res.mag[ch];
        q[ch]   <= '0;
        sat[ch] <= (rgbc_pkg::MAG_BITS+1)'(res.mag[ch])
                   >= ((rgbc_pkg::MAG_BITS+1)'(dpos) << rgbc_pkg::QBITS);
      end
    end else if (busy) begin
      dsh <= dsh >> 1;
      for (int ch = 0; ch < rgbc_pkg::NCH; ch++) begin
        if (rem[ch] >= dsh) begin
          rem[ch] <= rem[ch] - dsh;
          q[ch]   <= {q[ch][rgbc_pkg::QBITS-2:0], 1'b1};
        end else begin
          q[ch]   <= {q[ch][rgbc_pkg::QBITS-2:0], 1'b0};
        end
      end
    end
  end

  // Final selection: non-positive divisor gives zero, overflow gives full scale.
  always_comb begin
    for (int ch = 0; ch < rgbc_pkg::NCH; ch++) begin
      if (zero) begin
        quo[ch] = '0;
      end else if (sat[ch]) begin
        quo[ch] = '1;
      end else begin
        quo[ch] = q[ch];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rgb_conv3x3_kernel_filter.sv
// Top level of the RGB 3x3 convolution filter: controller, window, line store and output register.
// Depends on rgbc_pkg, rgbc_line_mem, rgbc_conv and rgbc_div.
`timescale 1ns / 1ps
`default_nettype none

// The filter takes RGB pixels of a frame in raster order and returns each pixel convolved with a
// selectable 3x3 kernel, edges replicated, each channel made absolute, divided and clamped to 255.
// Outputs trail the input by one row plus one pixel; once the last pixel of a frame is in, flush
// beats (or further pixel beats, whose data is then ignored) drain the remaining outputs, one per
// beat. The frame size is taken from frame_width and frame_height at the first pixel of a frame.
// The block works on one beat at a time: a beat that produces an output passes the visit, the
// multiply-accumulate unit, the divider steps shared by the three channels and the output
// register before the next beat is taken; a drain beat that needs a second visit also passes a
// line store read, and a stalled output register holds the block until it can load. A beat
// that produces nothing passes only the visit, and an ignored flush not even that. A result
// waiting in the output register does not hold off the next input beat until another result
// is ready. The line store needs no clearing after reset.
module rgb_conv3x3_kernel_filter #(
  parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration write port
  input  wire logic                               cfg_write,
  input  wire logic [rgbc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [rgbc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               op,
  input  wire logic [rgbc_pkg::CH_BITS-1:0]       in_red,
  input  wire logic [rgbc_pkg::CH_BITS-1:0]       in_green,
  input  wire logic [rgbc_pkg::CH_BITS-1:0]       in_blue,
  // Output channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [rgbc_pkg::CH_BITS-1:0]            out_red,
  output logic [rgbc_pkg::CH_BITS-1:0]            out_green,
  output logic [rgbc_pkg::CH_BITS-1:0]            out_blue,
  output logic [rgbc_pkg::COORD_BITS-1:0]         out_col,
  output logic [rgbc_pkg::COORD_BITS-1:0]         out_row,
  output logic                                    frame_done
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int AWW = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int AHW = $clog2(MAX_HEIGHT + 1);
  localparam int ACT_W_RST = (rgbc_pkg::FRAME_DIM_RST > MAX_WIDTH)
                             ? MAX_WIDTH : rgbc_pkg::FRAME_DIM_RST;
  localparam int ACT_H_RST = (rgbc_pkg::FRAME_DIM_RST > MAX_HEIGHT)
                             ? MAX_HEIGHT : rgbc_pkg::FRAME_DIM_RST;

  // Configuration registers.
  rgbc_pkg::ksel_t                ksel;
  rgbc_pkg::rows_t                custom;
  logic [rgbc_pkg::DIM_BITS-1:0]  frame_width;
  logic [rgbc_pkg::DIM_BITS-1:0]  frame_height;

  // Controller state.
  rgbc_pkg::state_t  state;
  logic [CW-1:0]     in_col;
  logic [RW-1:0]     in_row;
  logic [AWW-1:0]    act_w;
  logic [AHW-1:0]    act_h;
  logic              second_ok;
  rgbc_pkg::pix_t    pix;
  rgbc_pkg::win_t    win;
  rgbc_pkg::win_t    ewin;
  logic [CW-1:0]     e_col;
  logic [RW-1:0]     e_row;
  logic              e_last;

  // Line store port signals.
  logic                              mem_re;
  logic                              mem_we;
  logic [2*rgbc_pkg::PIX_BITS-1:0]   mem_rdata;
  logic [2*rgbc_pkg::PIX_BITS-1:0]   mem_wdata;

  // Visit decode.
  logic                 accept;
  logic                 emit_a;
  logic                 emit_b;
  logic                 in_frame;
  logic                 last_a;
  rgbc_pkg::pix_t       upper_rd;
  rgbc_pkg::pix_t       lower_rd;
  rgbc_pkg::pix_t       top_px;
  rgbc_pkg::pix_t       mid_px;
  rgbc_pkg::pix_t       bot_px;
  rgbc_pkg::pix_t       colv [rgbc_pkg::KSIZE];
  rgbc_pkg::win_t       sw;
  rgbc_pkg::win_t       nw;
  rgbc_pkg::win_t       win_next;
  logic [CW:0]          col_inc;
  logic [CW-1:0]        in_col_next;
  logic [RW-1:0]        in_row_next;
  logic [RW-1:0]        act_h_r;

  // Arithmetic units.
  logic                 conv_start;
  logic                 conv_done;
  rgbc_pkg::conv_res_t  conv_res;
  logic                 div_done;
  rgbc_pkg::chans_t     quo;
  logic                 load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != rgbc_pkg::S_IDLE);
  assign act_h_r  = RW'(act_h);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ksel         <= rgbc_pkg::KSEL_MEAN;
      custom       <= '0;
      frame_width  <= rgbc_pkg::DIM_BITS'(rgbc_pkg::FRAME_DIM_RST);
      frame_height <= rgbc_pkg::DIM_BITS'(rgbc_pkg::FRAME_DIM_RST);
    end else if (cfg_write) begin
      case (cfg_addr)
        rgbc_pkg::REG_KSEL:       ksel         <= cfg_wdata[rgbc_pkg::SEL_BITS-1:0];
        rgbc_pkg::REG_ROW_TOP:    custom[0]    <= cfg_wdata;
        rgbc_pkg::REG_ROW_MID:    custom[1]    <= cfg_wdata;
        rgbc_pkg::REG_ROW_BOTTOM: custom[2]    <= cfg_wdata;
        rgbc_pkg::REG_WIDTH:      frame_width  <= cfg_wdata[rgbc_pkg::DIM_BITS-1:0];
        rgbc_pkg::REG_HEIGHT:     frame_height <= cfg_wdata[rgbc_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Line store; read at the current input column on acceptance or for a second drain visit.
  assign mem_re    = accept || (state == rgbc_pkg::S_RD);
  assign mem_we    = (state == rgbc_pkg::S_VISIT) && in_frame;
  assign mem_wdata = {mid_px, bot_px};
  assign upper_rd  = mem_rdata[2*rgbc_pkg::PIX_BITS-1:rgbc_pkg::PIX_BITS];
  assign lower_rd  = mem_rdata[rgbc_pkg::PIX_BITS-1:0];

  rgbc_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_col),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (in_col),
    .rdata (mem_rdata)
  );

  // Column of the new position: replicated above the first row and below the last.
  always_comb begin
    emit_a   = (in_col == '0) && (in_row >= RW'(2));
    in_frame = (in_row <= act_h_r);
    emit_b   = in_frame && (in_row != '0) && (in_col != '0);
    last_a   = emit_a && (in_row == act_h_r + RW'(1));
    mid_px   = (in_row != '0) ? lower_rd : '0;
    top_px   = (in_row >= RW'(2)) ? upper_rd : mid_px;
    bot_px   = ((in_row != '0) && (in_row == act_h_r)) ? mid_px : pix;
    colv[0]  = top_px;
    colv[1]  = mid_px;
    colv[2]  = bot_px;
  end

  // Window shifts: right edge replication and loading of the new column.
  always_comb begin
    int k;
    for (int r = 0; r < rgbc_pkg::KSIZE; r++) begin
      k = r * rgbc_pkg::KSIZE;
      sw[k]     = win[k + 1];
      sw[k + 1] = win[k + 2];
      sw[k + 2] = win[k + 2];
      if (in_col == '0) begin
        nw[k]     = colv[r];
        nw[k + 1] = colv[r];
      end else begin
        nw[k]     = win[k + 1];
        nw[k + 1] = win[k + 2];
      end
      nw[k + 2] = colv[r];
    end
    if (in_frame) begin
      win_next = nw;
    end else if (emit_a) begin
      win_next = sw;
    end else begin
      win_next = win;
    end
  end

  // Raster position after this visit.
  always_comb begin
    col_inc = {1'b0, in_col} + (CW+1)'(1);
    if (last_a) begin
      in_col_next = '0;
      in_row_next = '0;
    end else if (col_inc >= (CW+1)'(act_w)) begin
      in_col_next = '0;
      in_row_next = in_row + RW'(1);
    end else begin
      in_col_next = col_inc[CW-1:0];
      in_row_next = in_row;
    end
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rgbc_pkg::S_IDLE;
      in_col    <= '0;
      in_row    <= '0;
      act_w     <= AWW'(ACT_W_RST);
      act_h     <= AHW'(ACT_H_RST);
      second_ok <= 1'b0;
      win       <= '0;
    end else begin
      case (state)
        rgbc_pkg::S_IDLE: begin
          if (accept) begin
            if (in_row < act_h_r) begin
              if (op == rgbc_pkg::OP_PIXEL) begin
                second_ok <= 1'b0;
                state     <= rgbc_pkg::S_VISIT;
                // Frame size is taken at the first pixel of a frame.
                if ((in_row == '0) && (in_col == '0)) begin
                  if (frame_width == '0) begin
                    act_w <= AWW'(1);
                  end else if (32'(frame_width) > MAX_WIDTH) begin
                    act_w <= AWW'(MAX_WIDTH);
                  end else begin
                    act_w <= AWW'(frame_width);
                  end
                  if (frame_height == '0) begin
                    act_h <= AHW'(1);
                  end else if (32'(frame_height) > MAX_HEIGHT) begin
                    act_h <= AHW'(MAX_HEIGHT);
                  end else begin
                    act_h <= AHW'(frame_height);
                  end
                end
              end
            end else begin
              // Frame fully in: this beat drains.
              second_ok <= 1'b1;
              state     <= rgbc_pkg::S_VISIT;
            end
          end
        end
        rgbc_pkg::S_VISIT: begin
          win    <= win_next;
          in_col <= in_col_next;
          in_row <= in_row_next;
          if (emit_a || emit_b) begin
            state <= rgbc_pkg::S_CONV;
          end else if (second_ok && (in_row_next >= act_h_r)) begin
            second_ok <= 1'b0;
            state     <= rgbc_pkg::S_RD;
          end else begin
            state <= rgbc_pkg::S_IDLE;
          end
        end
        rgbc_pkg::S_RD: begin
          state <= rgbc_pkg::S_VISIT;
        end
        rgbc_pkg::S_CONV: begin
          if (conv_done) begin
            state <= rgbc_pkg::S_DIV;
          end
        end
        rgbc_pkg::S_DIV: begin
          if (div_done) begin
            state <= rgbc_pkg::S_PUSH;
          end
        end
        rgbc_pkg::S_PUSH: begin
          if (load_out) begin
            state <= rgbc_pkg::S_IDLE;
          end
        end
        default: state <= rgbc_pkg::S_IDLE;
      endcase
    end
  end

  // Beat data and the window snapshot of an emitted pixel.
  always_ff @(posedge clk) begin
    if ((state == rgbc_pkg::S_IDLE) && accept) begin
      pix <= (op == rgbc_pkg::OP_PIXEL && in_row < act_h_r) ? {in_red, in_green, in_blue} : '0;
    end
    if (state == rgbc_pkg::S_VISIT) begin
      ewin   <= emit_a ? sw : nw;
      e_last <= last_a;
      if (emit_a) begin
        e_row <= in_row - RW'(2);
        e_col <= CW'(act_w - AWW'(1));
      end else begin
        e_row <= in_row - RW'(1);
        e_col <= in_col - CW'(1);
      end
    end
  end

  // Multiply-accumulate and divide; the arithmetic starts once the window snapshot is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      conv_start <= 1'b0;
    end else begin
      conv_start <= (state == rgbc_pkg::S_VISIT) && (emit_a || emit_b);
    end
  end

  rgbc_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .win    (ewin),
    .ksel   (ksel),
    .custom (custom),
    .done   (conv_done),
    .res    (conv_res)
  );

  rgbc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (conv_done),
    .res   (conv_res),
    .done  (div_done),
    .quo   (quo)
  );

  // Output register.
  assign load_out = (state == rgbc_pkg::S_PUSH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red    <= quo[0];
      out_green  <= quo[1];
      out_blue   <= quo[2];
      out_col    <= rgbc_pkg::COORD_BITS'(e_col);
      out_row    <= rgbc_pkg::COORD_BITS'(e_row);
      frame_done <= e_last;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rgbc_checker.sv
// Port-level checks of the RGB 3x3 convolution filter, bound to its top level.
// Depends on rgbc_pkg for field widths and on rgb_conv3x3_kernel_filter as bind target.
`timescale 1ns / 1ps
`default_nettype none

module rgbc_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [rgbc_pkg::CH_BITS-1:0]       out_red,
  input wire logic [rgbc_pkg::CH_BITS-1:0]       out_green,
  input wire logic [rgbc_pkg::CH_BITS-1:0]       out_blue,
  input wire logic [rgbc_pkg::COORD_BITS-1:0]    out_col,
  input wire logic [rgbc_pkg::COORD_BITS-1:0]    out_row,
  input wire logic                               frame_done
);

  // No result is shown right after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A new result appears only while the input side is held off by work in progress.
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while input was open");

  // A stalled result stays.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green) && $stable(out_blue)
                               && $stable(out_col) && $stable(out_row) && $stable(frame_done))
    else $error("stalled result changed");

endmodule

bind rgb_conv3x3_kernel_filter rgbc_checker u_rgbc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_red    (out_red),
  .out_green  (out_green),
  .out_blue   (out_blue),
  .out_col    (out_col),
  .out_row    (out_row),
  .frame_done (frame_done)
);

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the RGB 3x3 convolution filter.
// Depends on rgbc_pkg and rgb_conv3x3_kernel_filter; a built-in predictor checks every beat.
`timescale 1ns / 1ps

module tb;
  import rgbc_pkg::*;

  // Kernel selection codes beyond those in the package.
  localparam ksel_t KSEL_ENHANCE = 3'd2;
  localparam ksel_t KSEL_LOWPASS = 3'd3;
  localparam ksel_t KSEL_SHARPEN = 3'd4;
  localparam ksel_t KSEL_LAPLACE = 3'd5;
  localparam ksel_t KSEL_SOBELX  = 3'd6;
  localparam ksel_t KSEL_SOBELY  = 3'd7;
  localparam int    IDLE_LIMIT   = 5000;
  localparam int    SETTLE       = 30;

  // Built-in kernels, row-major, and their divisors.
  localparam int KERN [8][9] = '{
    '{ 0,  0,  0,  0,   0,  0,  0,  0,  0},
    '{ 1,  1,  1,  1,   1,  1,  1,  1,  1},
    '{ 1,  2,  1,  2, -12,  2,  1,  2,  1},
    '{ 1,  1,  1,  1,   8,  1,  1,  1,  1},
    '{ 0, -1,  0, -1,   5, -1,  0, -1,  0},
    '{ 0,  1,  0,  1,  -4,  1,  0,  1,  0},
    '{-1,  0,  1, -2,   0,  2, -1,  0,  1},
    '{-1, -2, -1,  0,   0,  0,  1,  2,  1}
  };
  localparam int KDIVS [8] = '{1, 9, 1, 16, 5, 1, 4, 4};

  typedef struct {
    logic [7:0] red, green, blue;
    logic [9:0] col, row;
    logic       done;
  } pix_res_t;

  typedef struct {
    ksel_t       ks;
    logic [23:0] rows [3];
    logic [10:0] w, h;
  } frame_cfg_t;

  typedef struct {
    logic       op;
    logic [7:0] red, green, blue;
    logic       typed;
    pix_res_t   res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_PIXEL;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic [9:0] out_col, out_row;
  logic frame_done;

  rgb_conv3x3_kernel_filter i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_col(out_col), .out_row(out_row), .frame_done(frame_done)
  );

  always #10 clk = ~clk;

  // Predictor state: line stores, window, raster counters and registers.
  logic [23:0] pr_upper [1024];
  logic [23:0] pr_lower [1024];
  logic [23:0] pr_win [9];
  int unsigned pr_col, pr_row, pr_w, pr_h;
  ksel_t       pr_ks;
  logic [23:0] pr_cust [3];
  logic [10:0] pr_fw, pr_fh;
  pix_res_t    filtered_q [$];

  int errors = 0;
  int n_in = 0, n_out = 0, n_frames = 0, rand_items = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic int unsigned clamp_dim(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic int coef(int r, int c);
    if (pr_ks != KSEL_CUSTOM) return KERN[pr_ks][r*3+c];
    return int'($signed(pr_cust[r][c*8 +: 8]));
  endfunction

  // Convolve the current window and queue the filtered pixel.
  function automatic void filter_pixel(int unsigned row, int unsigned col);
    int dv;
    int acc;
    int q;
    pix_res_t res;
    logic [7:0] chv [3];
    dv = 0;
    if (pr_ks != KSEL_CUSTOM) dv = KDIVS[pr_ks];
    else begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) dv += coef(r, c);
      if (dv == 0) dv = 1;
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          acc += int'(pr_win[i*3+j][16-8*ch +: 8]) * coef(2 - i, 2 - j);
      if (acc < 0) acc = -acc;
      q = (dv <= 0) ? 0 : acc / dv;
      chv[ch] = (q > 255) ? 8'd255 : q[7:0];
    end
    res.red   = chv[0];
    res.green = chv[1];
    res.blue  = chv[2];
    res.col   = col[9:0];
    res.row   = row[9:0];
    res.done  = (row == pr_h - 1 && col == pr_w - 1);
    filtered_q.push_back(res);
  endfunction

  // Advance one raster position, real or past the bottom edge.
  function automatic int raster_visit(logic [23:0] p);
    int unsigned ir, ic;
    int n;
    bit last;
    logic [23:0] cv [3];
    ir = pr_row;
    ic = pr_col;
    n = 0;
    last = 0;
    if (ic == 0 && ir >= 2) begin
      for (int r = 0; r < 3; r++) begin
        pr_win[r*3]   = pr_win[r*3+1];
        pr_win[r*3+1] = pr_win[r*3+2];
      end
      filter_pixel(ir - 2, pr_w - 1);
      n = 1;
      last = (ir - 2 == pr_h - 1);
    end
    if (ir <= pr_h) begin
      cv[0] = 0;
      cv[1] = 0;
      cv[2] = p;
      if (ir >= 1) begin
        cv[1] = pr_lower[ic];
        cv[0] = (ir >= 2) ? pr_upper[ic] : cv[1];
        if (ir == pr_h) cv[2] = cv[1];
        pr_upper[ic] = cv[1];
      end
      pr_lower[ic] = cv[2];
      for (int r = 0; r < 3; r++) begin
        if (ic == 0) begin
          pr_win[r*3]   = cv[r];
          pr_win[r*3+1] = cv[r];
        end else begin
          pr_win[r*3]   = pr_win[r*3+1];
          pr_win[r*3+1] = pr_win[r*3+2];
        end
        pr_win[r*3+2] = cv[r];
      end
      if (ir >= 1 && ic >= 1) begin
        filter_pixel(ir - 1, ic - 1);
        n = 1;
        last = (ir - 1 == pr_h - 1 && ic - 1 == pr_w - 1);
      end
    end
    pr_col = ic + 1;
    if (pr_col >= pr_w) begin
      pr_col = 0;
      pr_row = ir + 1;
    end
    if (last) begin
      pr_col = 0;
      pr_row = 0;
    end
    return n;
  endfunction

  // Apply one accepted input beat to the predictor.
  function automatic void predict_beat(logic o, logic [23:0] p);
    int n;
    if (o == OP_PIXEL && pr_row < pr_h) begin
      if (pr_row == 0 && pr_col == 0) begin
        pr_w = clamp_dim(pr_fw);
        pr_h = clamp_dim(pr_fh);
      end
      void'(raster_visit(p));
    end else if (pr_row >= pr_h) begin
      n = raster_visit(24'd0);
      if (n == 0 && pr_row >= pr_h) void'(raster_visit(24'd0));
    end
  endfunction

  // Drive one beat and wait for it to be taken; bursts end in random gaps.
  task automatic send_beat(logic o, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    op       <= o;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_beat(o, {r, g, b});
    n_in++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_KSEL:       pr_ks = val[2:0];
      REG_ROW_TOP:    pr_cust[0] = val;
      REG_ROW_MID:    pr_cust[1] = val;
      REG_ROW_BOTTOM: pr_cust[2] = val;
      REG_WIDTH:      pr_fw = val[10:0];
      REG_HEIGHT:     pr_fh = val[10:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(frame_cfg_t fc);
    wait_drained();
    write_reg(REG_KSEL, 24'(fc.ks));
    write_reg(REG_ROW_TOP, fc.rows[0]);
    write_reg(REG_ROW_MID, fc.rows[1]);
    write_reg(REG_ROW_BOTTOM, fc.rows[2]);
    write_reg(REG_WIDTH, 24'(fc.w));
    write_reg(REG_HEIGHT, 24'(fc.h));
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stream one whole frame with stray flushes, then drain it.
  task automatic run_frame(frame_cfg_t fc, bit counted);
    int unsigned npix;
    load_cfg(fc);
    npix = clamp_dim(fc.w) * clamp_dim(fc.h);
    for (int unsigned k = 0; k < npix; k++) begin
      if ($urandom_range(0, 7) == 0) send_beat(OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
      send_beat(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      if (counted) rand_items++;
    end
    while (!(pr_row == 0 && pr_col == 0)) begin
      send_beat($urandom_range(0, 2) == 0 ? OP_PIXEL : OP_FLUSH,
                rand_chan(), rand_chan(), rand_chan());
      if (counted) rand_items++;
    end
    // Flushes with nothing pending are ignored.
    repeat ($urandom_range(0, 2)) send_beat(OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
    n_frames++;
  endtask

  function automatic frame_cfg_t rand_cfg();
    frame_cfg_t fc;
    fc.ks = ksel_t'($urandom_range(0, 7));
    for (int r = 0; r < 3; r++) fc.rows[r] = 24'($urandom());
    fc.w = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(1, 40)) : 11'($urandom_range(1, 8));
    fc.h = 11'($urandom_range(1, 6));
    return fc;
  endfunction

  // Receiver stall pattern: changes its mood periodically, as stall_tick runs.
  int stall_mode = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 50 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare each output beat with the oldest prediction.
  always @(posedge clk) begin
    pix_res_t e;
    if (!rst && out_valid && !out_stall) begin
      n_out++;
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output beat row %0d col %0d", $time, out_row, out_col);
      end else begin
        e = filtered_q.pop_front();
        if ({out_red, out_green, out_blue} !== {e.red, e.green, e.blue}) begin
          errors++;
          $display("%0t: rgb expected %h %h %h, got %h %h %h", $time,
                   e.red, e.green, e.blue, out_red, out_green, out_blue);
        end
        if (out_col !== e.col || out_row !== e.row) begin
          errors++;
          $display("%0t: position expected r%0d c%0d, got r%0d c%0d", $time,
                   e.row, e.col, out_row, out_col);
        end
        if (frame_done !== e.done) begin
          errors++;
          $display("%0t: frame_done expected %b, got %b", $time, e.done, frame_done);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t   dir [6];
    frame_cfg_t fc;
    pix_res_t   blank;
    for (int k = 0; k < 1024; k++) begin
      pr_upper[k] = '0;
      pr_lower[k] = '0;
    end
    for (int k = 0; k < 9; k++) pr_win[k] = '0;
    pr_col = 0;
    pr_row = 0;
    pr_ks = KSEL_MEAN;
    for (int r = 0; r < 3; r++) pr_cust[r] = '0;
    pr_fw = 11'd1024;
    pr_fh = 11'd1024;
    pr_w = 1024;
    pr_h = 1024;
    blank = '{default: '0};

    // Directed part on a one-pixel frame with the mean kernel.
    dir[0] = '{OP_FLUSH, 8'd7, 8'd7, 8'd7, 1'b0, blank};
    dir[1] = '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, blank};
    dir[2] = '{OP_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd255, 8'd255, 8'd255, 10'd0, 10'd0, 1'b1}};
    dir[3] = '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, blank};
    dir[4] = '{OP_PIXEL, 8'd12, 8'd34, 8'd56, 1'b1, '{8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b1}};
    dir[5] = '{OP_FLUSH, 8'd255, 8'd255, 8'd255, 1'b0, blank};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 20);
    fc.ks = KSEL_MEAN;
    fc.rows = '{24'd0, 24'd0, 24'd0};
    fc.w = 11'd1;
    fc.h = 11'd1;
    load_cfg(fc);
    foreach (dir[k]) begin
      send_beat(dir[k].op, dir[k].red, dir[k].green, dir[k].blue);
      if (dir[k].typed) begin
        if (filtered_q.size() != 0) void'(filtered_q.pop_back());
        filtered_q.push_back(dir[k].res);
      end
    end

    // Every kernel once, then the custom extremes and the frame size limits.
    for (int k = 0; k < 8; k++) begin
      fc = rand_cfg();
      fc.ks = ksel_t'(k);
      run_frame(fc, 0);
    end
    fc.ks = KSEL_CUSTOM;
    fc.w = 11'd3;
    fc.h = 11'd3;
    fc.rows = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
    run_frame(fc, 0);
    fc.rows = '{24'h0001FF, 24'h7F0081, 24'h000000};
    run_frame(fc, 0);
    fc.rows = '{24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F};
    run_frame(fc, 0);
    fc.rows = '{24'h808080, 24'h808080, 24'h808080};
    run_frame(fc, 0);
    fc.rows = '{24'h000000, 24'h000000, 24'h000000};
    run_frame(fc, 0);
    fc.ks = KSEL_SHARPEN;
    fc.w = 11'd0;
    fc.h = 11'd4;
    run_frame(fc, 0);
    fc.ks = KSEL_SOBELY;
    fc.w = 11'd6;
    fc.h = 11'd0;
    run_frame(fc, 0);
    fc.ks = KSEL_LAPLACE;
    fc.w = 11'd0;
    fc.h = 11'd0;
    run_frame(fc, 0);

    // Random frames.
    while (n_in < 550) run_frame(rand_cfg(), 1);

    wait_drained();
    $display("tb: %0d beats in (%0d in random frames), %0d beats out over %0d frames,", n_in,
             rand_items, n_out, n_frames);
    $display("tb: all eight kernels, custom extremes, zero frame sizes, stray and idle flushes");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/rgbc_pkg.sv
hw/rtl/rgbc_line_mem.sv
hw/rtl/rgbc_conv.sv
hw/rtl/rgbc_div.sv
hw/rtl/rgb_conv3x3_kernel_filter.sv
hw/rtl/rgbc_checker.sv
verif/tb.sv
